// ===== sv/lche_pkg.sv =====
// ============================================================================
// lche_pkg
// shared types and constants of the lattice convex hull engine
// ============================================================================
package lche_pkg;

    localparam int X_W        = 5;
    localparam int Y_W        = 7;
    localparam int CNT_W      = 13;
    localparam int VC_W       = 8;
    localparam int VI_W       = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_S1 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_S2 = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_INTERIOR,
        CMD_COUNT,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } point_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_RB_INIT,
        ST_SC_RD,
        ST_SC_CHK,
        ST_POP_RD,
        ST_POP_CHK,
        ST_PUSH,
        ST_END_PASS,
        ST_Q_START,
        ST_Q_VX,
        ST_IN_SEEN,
        ST_IN_RD,
        ST_IN_CHK
    } state_t;

endpackage

// ===== sv/lche_turn.sv =====
// ============================================================================
// lche_turn
// orientation test: is o -> a -> b a strict left turn
// ============================================================================
module lche_turn
(
    input  lche_pkg::point_t o,
    input  lche_pkg::point_t a,
    input  lche_pkg::point_t b,
    output logic             left
);
    import lche_pkg::*;

    logic signed [X_W:0]     d1x;
    logic signed [X_W:0]     d2x;
    logic signed [Y_W:0]     d1y;
    logic signed [Y_W:0]     d2y;
    logic signed [X_W+Y_W+2:0] p1;
    logic signed [X_W+Y_W+2:0] p2;
    logic signed [X_W+Y_W+3:0] cr;

    always_comb
    begin
        d1x = $signed({1'b0, a.x}) - $signed({1'b0, o.x});
        d2x = $signed({1'b0, b.x}) - $signed({1'b0, o.x});
        d1y = $signed({1'b0, a.y}) - $signed({1'b0, o.y});
        d2y = $signed({1'b0, b.y}) - $signed({1'b0, o.y});
        p1  = d1x * d2y;
        p2  = d1y * d2x;
        cr  = $signed({p1[X_W+Y_W+2], p1}) - $signed({p2[X_W+Y_W+2], p2});
        left = !cr[X_W+Y_W+3] && (cr != '0);
    end

endmodule

// ===== sv/lattice_convex_hull_engine_core.sv =====
// ============================================================================
// lattice_convex_hull_engine_core
// point bitmap with lazily rebuilt convex hull and hull queries
// ============================================================================
// After reset the block clears its point memory, one cell a cycle, with busy
// high. A request is taken when start is high and busy low; its result shows
// on the output ports for one cycle with done. An add writes the point memory,
// a vertex read reads the hull chain, and an interior query out of the box
// ends without a test, else it tests the hull edges in turn until one fails.
// A query on a stale hull first rebuilds it: one pass over the box, and a
// second, reversed pass when at least two points are seen, each reading the
// point memory cell by cell and pushing to and popping from the chain memory.
module lattice_convex_hull_engine_core
#(
    parameter int GRID_X      = 32,
    parameter int GRID_Y      = 128,
    parameter int CHAIN_DEPTH = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lche_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lche_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [lche_pkg::X_W-1:0]          point_x,
    input  logic [lche_pkg::Y_W-1:0]          point_y,
    input  logic [lche_pkg::VI_W-1:0]         vertex_index,
    output logic                              done,
    output logic                              is_interior,
    output logic [lche_pkg::VC_W-1:0]         vertex_count,
    output logic [lche_pkg::CNT_W-1:0]        observed_count,
    output logic [lche_pkg::X_W-1:0]          vertex_x,
    output logic [lche_pkg::Y_W-1:0]          vertex_y,
    output logic                              out_of_range,
    output logic                              chain_overflow
);
    import lche_pkg::*;

    localparam int CELLS  = GRID_X * GRID_Y;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(CHAIN_DEPTH);
    localparam int KW     = $clog2(CHAIN_DEPTH + 2);

    state_t               state_reg, state_next;
    logic [X_W-1:0]       s1_reg, s1_next;
    logic [Y_W-1:0]       s2_reg, s2_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [KW-1:0]        hull_reg, hull_next;
    logic                 stale_reg, stale_next;
    logic                 ovf_reg, ovf_next;
    logic                 done_reg, done_next;

    cmd_t                 cmd_reg, cmd_next;
    point_t               q_reg, q_next;
    logic [VI_W-1:0]      vi_reg, vi_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        t_reg, t_next;
    logic [1:0]           n_reg, n_next;
    logic                 pass_reg, pass_next;
    logic                 skip_reg, skip_next;
    point_t               f_reg, f_next;
    point_t               s_reg, s_next;
    logic [IDX_W-1:0]     i_reg, i_next;

    logic                 int_reg, int_next;
    logic [VC_W-1:0]      vc_reg, vc_next;
    logic [CNT_W-1:0]     oc_reg, oc_next;
    point_t               vp_reg, vp_next;
    logic                 oor_reg, oor_next;
    logic                 co_reg, co_next;

    logic                 seen_mem [CELLS];
    logic                 seen_we;
    logic [ADDR_W-1:0]    seen_waddr;
    logic                 seen_wdata;
    logic [ADDR_W-1:0]    seen_raddr;
    logic                 seen_q;

    point_t               chain_mem [CHAIN_DEPTH];
    logic                 chain_we;
    logic [IDX_W-1:0]     chain_waddr;
    point_t               chain_wdata;
    logic [IDX_W-1:0]     ra_addr;
    logic [IDX_W-1:0]     rb_addr;
    point_t               a_q;
    point_t               b_q;

    logic [X_W-1:0]       xm;
    logic [Y_W-1:0]       ym;
    logic                 q_inbox;
    logic                 adv_last;
    point_t               adv_pt;
    point_t               p_turn;
    logic                 left;
    logic [KW-1:0]        floor_k;
    logic                 can_pop;
    logic                 go_pop;
    logic                 k_full;
    logic                 vi_ok;
    logic                 i_last;
    logic [IDX_W-1:0]     j_idx;
    logic                 is_f;
    logic                 fin;
    logic                 fin_int;
    logic                 fin_oor;
    point_t               fin_pt;
    logic                 ins;

    function automatic logic [ADDR_W-1:0] cell_addr(point_t p);
        logic [31:0] a;
        a = 32'(p.x) * 32'(GRID_Y) + 32'(p.y);
        return a[ADDR_W-1:0];
    endfunction

    // memories
    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        seen_q <= seen_mem[seen_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (chain_we)
        begin
            chain_mem[chain_waddr] <= chain_wdata;
        end
        a_q <= chain_mem[ra_addr];
        b_q <= chain_mem[rb_addr];
    end

    lche_turn u_turn
    (
        .o    (a_q),
        .a    (b_q),
        .b    (p_turn),
        .left (left)
    );

    // helper conditions
    always_comb
    begin
        xm = (32'(s1_reg) < 32'(GRID_X - 1)) ? s1_reg : X_W'(GRID_X - 1);
        ym = (32'(s2_reg) < 32'(GRID_Y - 1)) ? s2_reg : Y_W'(GRID_Y - 1);
        q_inbox = (q_reg.x <= xm) && (q_reg.y <= ym);
        if (!pass_reg)
        begin
            adv_last = (s_reg.x == xm) && (s_reg.y == ym);
            adv_pt   = (s_reg.y == ym) ? point_t'{x: X_W'(s_reg.x + 1'b1), y: '0}
                                       : point_t'{x: s_reg.x, y: Y_W'(s_reg.y + 1'b1)};
        end
        else
        begin
            adv_last = (s_reg.x == '0) && (s_reg.y == '0);
            adv_pt   = (s_reg.y == '0) ? point_t'{x: X_W'(s_reg.x - 1'b1), y: ym}
                                       : point_t'{x: s_reg.x, y: Y_W'(s_reg.y - 1'b1)};
        end
        p_turn  = (state_reg == ST_IN_CHK) ? q_reg : s_reg;
        floor_k = pass_reg ? t_reg : KW'(2);
        can_pop = (k_reg >= floor_k) && (k_reg >= KW'(2));
        go_pop  = seen_q && (!pass_reg || skip_reg);
        k_full  = 32'(k_reg) >= 32'(CHAIN_DEPTH);
        vi_ok   = (32'(vi_reg) < 32'(hull_reg)) && (32'(vi_reg) < 32'(CHAIN_DEPTH));
        i_last  = (KW'(i_reg) + KW'(1)) == hull_reg;
        j_idx   = i_last ? '0 : i_reg + 1'b1;
        is_f    = (s_reg == f_reg);
        ins     = q_inbox && !seen_q;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_ADD)
                    begin
                        state_next = ST_ADD_WR;
                    end
                    else
                    begin
                        state_next = stale_reg ? ST_RB_INIT : ST_Q_START;
                    end
                end
            end
            ST_ADD_WR:   state_next = ST_IDLE;
            ST_RB_INIT:  state_next = ST_SC_RD;
            ST_SC_RD:    state_next = ST_SC_CHK;
            ST_SC_CHK:
            begin
                if (go_pop)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = adv_last ? ST_END_PASS : ST_SC_RD;
                end
            end
            ST_POP_RD:   state_next = can_pop ? ST_POP_CHK : ST_PUSH;
            ST_POP_CHK:  state_next = left ? ST_PUSH : ST_POP_RD;
            ST_PUSH:     state_next = adv_last ? ST_END_PASS : ST_SC_RD;
            ST_END_PASS:
            begin
                state_next = (!pass_reg && n_reg == 2'd2) ? ST_SC_RD : ST_Q_START;
            end
            ST_Q_START:
            begin
                unique case (cmd_reg)
                    CMD_READ:     state_next = vi_ok ? ST_Q_VX : ST_IDLE;
                    CMD_INTERIOR: state_next = q_inbox ? ST_IN_SEEN : ST_IDLE;
                    CMD_ADD,
                    CMD_COUNT:    state_next = ST_IDLE;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_Q_VX:     state_next = ST_IDLE;
            ST_IN_SEEN:
            begin
                state_next = (seen_q && hull_reg >= KW'(3)) ? ST_IN_RD : ST_IDLE;
            end
            ST_IN_RD:    state_next = ST_IN_CHK;
            ST_IN_CHK:   state_next = (left && !i_last) ? ST_IN_RD : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        clr_next   = clr_reg;
        total_next = total_reg;
        hull_next  = hull_reg;
        stale_next = stale_reg;
        ovf_next   = ovf_reg;
        cmd_next   = cmd_reg;
        q_next     = q_reg;
        vi_next    = vi_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        pass_next  = pass_reg;
        skip_next  = skip_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        i_next     = i_reg;
        int_next   = int_reg;
        vc_next    = vc_reg;
        oc_next    = oc_reg;
        vp_next    = vp_reg;
        oor_next   = oor_reg;
        co_next    = co_reg;
        done_next  = 1'b0;

        seen_we     = 1'b0;
        seen_waddr  = cell_addr(q_reg);
        seen_wdata  = 1'b1;
        seen_raddr  = cell_addr(s_reg);
        chain_we    = 1'b0;
        chain_waddr = IDX_W'(k_reg);
        chain_wdata = s_reg;
        ra_addr     = IDX_W'(k_reg - KW'(2));
        rb_addr     = IDX_W'(k_reg - KW'(1));

        fin     = 1'b0;
        fin_int = 1'b0;
        fin_oor = 1'b0;
        fin_pt  = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                seen_we    = 1'b1;
                seen_waddr = clr_reg;
                seen_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                seen_raddr = cell_addr('{x: point_x, y: point_y});
                if (start)
                begin
                    cmd_next = cmd_t'(command);
                    q_next   = '{x: point_x, y: point_y};
                    vi_next  = vertex_index;
                end
            end
            ST_ADD_WR:
            begin
                if (ins)
                begin
                    seen_we   = 1'b1;
                    stale_next = 1'b1;
                    if (total_reg != {CNT_W{1'b1}})
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                fin     = 1'b1;
                fin_oor = !q_inbox;
            end
            ST_RB_INIT:
            begin
                k_next    = '0;
                n_next    = '0;
                ovf_next  = 1'b0;
                pass_next = 1'b0;
                skip_next = 1'b0;
                s_next    = '0;
            end
            ST_SC_RD:
            begin
            end
            ST_SC_CHK:
            begin
                if (seen_q)
                begin
                    if (!pass_reg)
                    begin
                        if (n_reg == 2'd0)
                        begin
                            f_next = s_reg;
                        end
                        n_next = (n_reg == 2'd2) ? n_reg : n_reg + 1'b1;
                    end
                    else if (!skip_reg)
                    begin
                        skip_next = 1'b1;
                    end
                end
                if (!go_pop)
                begin
                    s_next = adv_pt;
                end
            end
            ST_POP_RD:
            begin
            end
            ST_POP_CHK:
            begin
                if (!left)
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (!(pass_reg && is_f))
                begin
                    if (k_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        chain_we = 1'b1;
                        k_next   = k_reg + 1'b1;
                    end
                end
                s_next = adv_pt;
            end
            ST_END_PASS:
            begin
                if (!pass_reg && n_reg == 2'd2)
                begin
                    t_next    = k_reg + 1'b1;
                    pass_next = 1'b1;
                    skip_next = 1'b0;
                    s_next    = '{x: xm, y: ym};
                end
                else
                begin
                    hull_next  = k_reg;
                    stale_next = 1'b0;
                end
            end
            ST_Q_START:
            begin
                seen_raddr = cell_addr(q_reg);
                ra_addr    = IDX_W'(32'(vi_reg));
                unique case (cmd_reg)
                    CMD_READ:
                    begin
                        fin = !vi_ok;
                    end
                    CMD_INTERIOR:
                    begin
                        fin     = !q_inbox;
                        fin_oor = !q_inbox;
                    end
                    CMD_ADD,
                    CMD_COUNT:
                    begin
                        fin = 1'b1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_Q_VX:
            begin
                fin    = 1'b1;
                fin_pt = a_q;
            end
            ST_IN_SEEN:
            begin
                i_next = '0;
                if (!(seen_q && hull_reg >= KW'(3)))
                begin
                    fin = 1'b1;
                end
            end
            ST_IN_RD:
            begin
                ra_addr = i_reg;
                rb_addr = j_idx;
            end
            ST_IN_CHK:
            begin
                if (!left || i_last)
                begin
                    fin     = 1'b1;
                    fin_int = left;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            done_next = 1'b1;
            int_next  = fin_int;
            vc_next   = (cmd_reg == CMD_ADD) ? '0 : VC_W'(hull_reg);
            oc_next   = total_next;
            vp_next   = fin_pt;
            oor_next  = fin_oor;
            co_next   = ovf_reg;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GRID_S1: s1_next = cfg_data[X_W-1:0];
                CFG_GRID_S2: s2_next = cfg_data[Y_W-1:0];
                default:     s2_next = s2_reg;
            endcase
            stale_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            s1_reg    <= X_W'(31);
            s2_reg    <= Y_W'(127);
            clr_reg   <= '0;
            total_reg <= '0;
            hull_reg  <= '0;
            stale_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            hull_reg  <= hull_next;
            stale_reg <= stale_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        q_reg    <= q_next;
        vi_reg   <= vi_next;
        k_reg    <= k_next;
        t_reg    <= t_next;
        n_reg    <= n_next;
        pass_reg <= pass_next;
        skip_reg <= skip_next;
        f_reg    <= f_next;
        s_reg    <= s_next;
        i_reg    <= i_next;
        int_reg  <= int_next;
        vc_reg   <= vc_next;
        oc_reg   <= oc_next;
        vp_reg   <= vp_next;
        oor_reg  <= oor_next;
        co_reg   <= co_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign is_interior    = int_reg;
    assign vertex_count   = vc_reg;
    assign observed_count = oc_reg;
    assign vertex_x       = vp_reg.x;
    assign vertex_y       = vp_reg.y;
    assign out_of_range   = oor_reg;
    assign chain_overflow = co_reg;

endmodule

// ===== sv/lche_checker.sv =====
// ============================================================================
// lche_checker
// port level checks of the lattice convex hull engine
// ============================================================================
module lche_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        is_interior,
    input logic [lche_pkg::VC_W-1:0]   vertex_count,
    input logic [lche_pkg::X_W-1:0]    vertex_x,
    input logic [lche_pkg::Y_W-1:0]    vertex_y,
    input logic                        out_of_range
);
    import lche_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_interior_hull: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_interior |-> vertex_count >= VC_W'(3) && !out_of_range)
        else $error("interior point without a proper hull");

    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> !is_interior && vertex_x == '0 && vertex_y == '0)
        else $error("out of range result carries data");

endmodule

bind lattice_convex_hull_engine_core lche_checker u_lche_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .is_interior  (is_interior),
    .vertex_count (vertex_count),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .out_of_range (out_of_range)
);
